[sv/matrix_inverse_3x3_core_defines.svh]
// assertion macros for the 3x3 matrix inverse core checker
`ifndef MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define MATRIX_INVERSE_3X3_CORE_DEFINES_SVH

// implication checked outside reset
`define MI3_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi3 check failed");

// next-cycle implication, also checked during reset
`define MI3_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mi3 check failed");

`endif

[sv/mi3_pkg.sv]
// types and constants for the 3x3 matrix inverse core
`default_nettype none
package mi3_pkg;
  localparam int ENTRY_W   = 32;
  localparam int COF_W     = 64;
  localparam int TERM_W    = 96;
  localparam int DET_W     = 98;
  localparam int DMAG_W    = 97;
  localparam int FRAC_SH   = 48;
  localparam int QUO_W     = 32;
  localparam int REM_W     = 129;
  localparam int N_ENT     = 9;
  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = QUO_W + 1;

  localparam logic [ENTRY_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ENTRY_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [COF_W-1:0]   cof_t;

  typedef struct packed {
    logic [COF_W-1:0] cm;
    logic             sgn;
  } lane_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] q;
    logic             sgn;
    logic             ovf;
    logic             czero;
  } lane_out_t;
endpackage
`default_nettype wire

[sv/mi3_if.sv]
// matrix input and inverse output channel interfaces
`default_nettype none
interface mi3_in_if;
  logic valid;
  logic ready;
  mi3_pkg::entry_t in_r0c0, in_r0c1, in_r0c2;
  mi3_pkg::entry_t in_r1c0, in_r1c1, in_r1c2;
  mi3_pkg::entry_t in_r2c0, in_r2c1, in_r2c2;
  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_out_if;
  logic valid;
  logic ready;
  mi3_pkg::entry_t out_r0c0, out_r0c1, out_r0c2;
  mi3_pkg::entry_t out_r1c0, out_r1c1, out_r1c2;
  mi3_pkg::entry_t out_r2c0, out_r2c1, out_r2c2;
  logic singular;
  logic saturated;
  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                  input ready);
  modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                output ready);
endinterface
`default_nettype wire

[sv/mi3_front.sv]
// cofactor and determinant pipeline feeding the divide lanes
`default_nettype none
module mi3_front (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire mi3_pkg::entry_t    a [mi3_pkg::N_ENT],
  output mi3_pkg::lane_in_t       lin [mi3_pkg::N_ENT],
  output logic [mi3_pkg::DMAG_W-1:0] dmag,
  output logic                    singular
);
  localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0,
                             3, 4, 1, 0, 0, 1};
  localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5,
                             7, 6, 6, 7, 4, 3};
  localparam int CI [3] = '{0, 3, 6};

  mi3_pkg::cof_t                   prod [18];
  mi3_pkg::entry_t                 a0_s1 [3];
  mi3_pkg::entry_t                 a0_s2 [3];
  mi3_pkg::cof_t                   adj_s2 [mi3_pkg::N_ENT];
  mi3_pkg::cof_t                   adj_s3 [mi3_pkg::N_ENT];
  mi3_pkg::cof_t                   adj_s4 [mi3_pkg::N_ENT];
  mi3_pkg::cof_t                   adj_s5 [mi3_pkg::N_ENT];
  logic signed [63:0]              ph [3];
  logic signed [64:0]              pl [3];
  logic signed [mi3_pkg::TERM_W-1:0] term [3];
  logic signed [mi3_pkg::DET_W-1:0] det;
  logic signed [mi3_pkg::DET_W-1:0] det_abs;

  // pairs are (PA[2k]*PB[2k]) - (PA[2k+1]*PB[2k+1]) over the flat entry order
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 18; k++) begin
        prod[k] <= mi3_pkg::cof_t'(a[PA[k]]) * mi3_pkg::cof_t'(a[PB[k]]);
      end
      for (int j = 0; j < 3; j++) begin
        a0_s1[j] <= a[j];
        a0_s2[j] <= a0_s1[j];
      end
      for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
        adj_s2[k] <= prod[2*k] - prod[2*k+1];
        adj_s3[k] <= adj_s2[k];
        adj_s4[k] <= adj_s3[k];
        adj_s5[k] <= adj_s4[k];
      end
      for (int j = 0; j < 3; j++) begin
        ph[j]   <= 64'(a0_s2[j]) * 64'($signed(adj_s2[CI[j]][63:32]));
        pl[j]   <= 65'(a0_s2[j]) * $signed({33'b0, adj_s2[CI[j]][31:0]});
        term[j] <= $signed({ph[j], 32'b0}) + mi3_pkg::TERM_W'(pl[j]);
      end
      det <= mi3_pkg::DET_W'(term[0]) + mi3_pkg::DET_W'(term[1])
           + mi3_pkg::DET_W'(term[2]);
      dmag     <= det_abs[mi3_pkg::DMAG_W-1:0];
      singular <= (det == '0);
      for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
        lin[k].cm  <= adj_s5[k][63] ? (64'd0 - adj_s5[k]) : adj_s5[k];
        lin[k].sgn <= adj_s5[k][63] ^ det[mi3_pkg::DET_W-1];
      end
    end
  end

  assign det_abs = det[mi3_pkg::DET_W-1] ? -det : det;
endmodule
`default_nettype wire

[sv/mi3_lane.sv]
// one divide lane: cofactor magnitude times 2^48 over determinant magnitude
`default_nettype none
module mi3_lane (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire mi3_pkg::lane_in_t     lin,
  input  wire logic [mi3_pkg::DMAG_W-1:0] dmag,
  output mi3_pkg::lane_out_t         lout
);
  localparam int QW = mi3_pkg::QUO_W;
  localparam int RW = mi3_pkg::REM_W;

  logic [RW-1:0]              rem  [QW+1];
  logic [mi3_pkg::DMAG_W-1:0] d    [QW+1];
  logic [QW-1:0]              q    [QW+1];
  logic                       sgn  [QW+1];
  logic                       ovf  [QW+1];
  logic                       cz   [QW+1];
  logic [RW-1:0]              num;
  logic [RW-1:0]              dtop;

  assign num  = RW'({lin.cm, {mi3_pkg::FRAC_SH{1'b0}}});
  assign dtop = RW'({dmag, {QW{1'b0}}});

  // quotient of 2^32 or more saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      d[0]   <= dmag;
      q[0]   <= '0;
      sgn[0] <= lin.sgn;
      ovf[0] <= (num >= dtop);
      cz[0]  <= (lin.cm == '0);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(d[k]) << (QW - 1 - k);
    assign ge  = (rem[k] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - dsh : rem[k];
        q[k+1]   <= q[k] | (QW'(ge) << (QW - 1 - k));
        d[k+1]   <= d[k];
        sgn[k+1] <= sgn[k];
        ovf[k+1] <= ovf[k];
        cz[k+1]  <= cz[k];
      end
    end
  end

  assign lout.q     = q[QW];
  assign lout.sgn   = sgn[QW];
  assign lout.ovf   = ovf[QW];
  assign lout.czero = cz[QW];
endmodule
`default_nettype wire

[sv/matrix_inverse_3x3_core.sv]
// 3x3 matrix inverse core: cofactor front, nine divide lanes, merge register
//
//  channel  dir  payload                                   transfer
//  in_ch    in   in_r0c0 .. in_r2c2                         valid & ready
//  out_ch   out  out_r0c0 .. out_r2c2, singular, saturated  valid & ready
//
// one matrix per cycle while the output register is not held; from input transfer to
// output valid a matrix passes 6 cofactor/determinant stages, 33 divide-lane stages, 1 merge
// the whole pipeline advances when the output register is empty or taken
// in_ch.ready follows that advance signal outside reset; bubbles move along
// synchronous reset clears only the valid bits
`default_nettype none
module matrix_inverse_3x3_core (
  input  wire logic  clk,
  input  wire logic  rst,
  mi3_in_if.sink     in_ch,
  mi3_out_if.source  out_ch
);
  localparam int NE    = mi3_pkg::N_ENT;
  localparam int TOTAL = mi3_pkg::FRONT_LAT + mi3_pkg::LANE_LAT;

  logic                       en;
  logic                       vld [TOTAL];
  logic                       sing_pipe [mi3_pkg::LANE_LAT];
  mi3_pkg::entry_t            a [NE];
  mi3_pkg::lane_in_t          lin [NE];
  mi3_pkg::lane_out_t         lout [NE];
  logic [mi3_pkg::DMAG_W-1:0] dmag;
  logic                       singular;
  mi3_pkg::entry_t            res_next [NE];
  logic                       clamp [NE];
  logic                       sat_next;
  mi3_pkg::entry_t            res [NE];
  logic                       out_valid;
  logic                       out_sing;
  logic                       out_sat;

  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en && !rst;

  assign a[0] = in_ch.in_r0c0;
  assign a[1] = in_ch.in_r0c1;
  assign a[2] = in_ch.in_r0c2;
  assign a[3] = in_ch.in_r1c0;
  assign a[4] = in_ch.in_r1c1;
  assign a[5] = in_ch.in_r1c2;
  assign a[6] = in_ch.in_r2c0;
  assign a[7] = in_ch.in_r2c1;
  assign a[8] = in_ch.in_r2c2;

  mi3_front u_front (
    .clk      (clk),
    .en       (en),
    .a        (a),
    .lin      (lin),
    .dmag     (dmag),
    .singular (singular)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    mi3_lane u_lane (
      .clk  (clk),
      .en   (en),
      .lin  (lin[k]),
      .dmag (dmag),
      .lout (lout[k])
    );
  end

  always_comb begin
    sat_next = 1'b0;
    for (int k = 0; k < NE; k++) begin
      clamp[k] = lout[k].ovf
               || (lout[k].q[mi3_pkg::QUO_W-1]
                   && !(lout[k].sgn && lout[k].q[mi3_pkg::QUO_W-2:0] == '0));
      if (sing_pipe[mi3_pkg::LANE_LAT-1] || lout[k].czero) begin
        res_next[k] = '0;
      end else if (clamp[k]) begin
        res_next[k] = lout[k].sgn ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
        sat_next    = 1'b1;
      end else begin
        res_next[k] = lout[k].sgn ? -$signed(lout[k].q) : $signed(lout[k].q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < TOTAL; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_ch.valid;
      for (int k = 1; k < TOTAL; k++) begin
        vld[k] <= vld[k-1];
      end
      out_valid <= vld[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_pipe[0] <= singular;
      for (int k = 1; k < mi3_pkg::LANE_LAT; k++) begin
        sing_pipe[k] <= sing_pipe[k-1];
      end
      for (int k = 0; k < NE; k++) begin
        res[k] <= res_next[k];
      end
      out_sing <= sing_pipe[mi3_pkg::LANE_LAT-1];
      out_sat  <= sat_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_r0c0  = res[0];
  assign out_ch.out_r0c1  = res[1];
  assign out_ch.out_r0c2  = res[2];
  assign out_ch.out_r1c0  = res[3];
  assign out_ch.out_r1c1  = res[4];
  assign out_ch.out_r1c2  = res[5];
  assign out_ch.out_r2c0  = res[6];
  assign out_ch.out_r2c1  = res[7];
  assign out_ch.out_r2c2  = res[8];
  assign out_ch.singular  = out_sing;
  assign out_ch.saturated = out_sat;
endmodule
`default_nettype wire

[sv/mi3_chk.sv]
// port-level checker for the 3x3 matrix inverse core, with its bind
`default_nettype none
`include "matrix_inverse_3x3_core_defines.svh"
module mi3_chk (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire mi3_pkg::entry_t out_r0c0,
  input wire mi3_pkg::entry_t out_r0c1,
  input wire mi3_pkg::entry_t out_r0c2,
  input wire mi3_pkg::entry_t out_r1c0,
  input wire mi3_pkg::entry_t out_r1c1,
  input wire mi3_pkg::entry_t out_r1c2,
  input wire mi3_pkg::entry_t out_r2c0,
  input wire mi3_pkg::entry_t out_r2c1,
  input wire mi3_pkg::entry_t out_r2c2,
  input wire logic            singular,
  input wire logic            saturated
);
  logic all_zero;
  logic any_clamp;

  assign all_zero = out_r0c0 == '0 && out_r0c1 == '0 && out_r0c2 == '0
                 && out_r1c0 == '0 && out_r1c1 == '0 && out_r1c2 == '0
                 && out_r2c0 == '0 && out_r2c1 == '0 && out_r2c2 == '0;

  assign any_clamp =
      out_r0c0 == mi3_pkg::SAT_POS || out_r0c0 == mi3_pkg::SAT_NEG
   || out_r0c1 == mi3_pkg::SAT_POS || out_r0c1 == mi3_pkg::SAT_NEG
   || out_r0c2 == mi3_pkg::SAT_POS || out_r0c2 == mi3_pkg::SAT_NEG
   || out_r1c0 == mi3_pkg::SAT_POS || out_r1c0 == mi3_pkg::SAT_NEG
   || out_r1c1 == mi3_pkg::SAT_POS || out_r1c1 == mi3_pkg::SAT_NEG
   || out_r1c2 == mi3_pkg::SAT_POS || out_r1c2 == mi3_pkg::SAT_NEG
   || out_r2c0 == mi3_pkg::SAT_POS || out_r2c0 == mi3_pkg::SAT_NEG
   || out_r2c1 == mi3_pkg::SAT_POS || out_r2c1 == mi3_pkg::SAT_NEG
   || out_r2c2 == mi3_pkg::SAT_POS || out_r2c2 == mi3_pkg::SAT_NEG;

  `MI3_ASSERT_IMPL(a_singular_zero, out_valid && singular, all_zero && !saturated)
  `MI3_ASSERT_IMPL(a_sat_clamped, out_valid && saturated, any_clamp && !singular)
  `MI3_ASSERT_IMPL(a_backpressure, out_valid && !out_ready, !in_ready)
  `MI3_ASSERT_NEXT(a_reset_empty, rst, !out_valid)
endmodule

bind matrix_inverse_3x3_core mi3_chk u_mi3_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_r0c0  (out_ch.out_r0c0),
  .out_r0c1  (out_ch.out_r0c1),
  .out_r0c2  (out_ch.out_r0c2),
  .out_r1c0  (out_ch.out_r1c0),
  .out_r1c1  (out_ch.out_r1c1),
  .out_r1c2  (out_ch.out_r1c2),
  .out_r2c0  (out_ch.out_r2c0),
  .out_r2c1  (out_ch.out_r2c1),
  .out_r2c2  (out_ch.out_r2c2),
  .singular  (out_ch.singular),
  .saturated (out_ch.saturated)
);
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the 3x3 matrix inverse core with random stalls
`default_nettype none
module tb_top;
  typedef struct packed {
    mi3_pkg::entry_t [8:0] e;
  } mat_t;

  typedef struct packed {
    mi3_pkg::entry_t [8:0] e;
    logic                  singular;
    logic                  saturated;
  } inv_t;

  typedef struct {
    mat_t m;
    logic known;
    inv_t res;
  } row_t;

  localparam int N_RAND    = 1150;
  localparam int CYC_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();

  matrix_inverse_3x3_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  inv_t inv_q[$];
  int   errors = 0;
  int   cycles = 0;
  bit   calm   = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic signed [63:0] mul2(mi3_pkg::entry_t a, mi3_pkg::entry_t b,
                                              mi3_pkg::entry_t c, mi3_pkg::entry_t d);
    logic signed [63:0] p, q;
    p = 64'(a) * 64'(b);
    q = 64'(c) * 64'(d);
    return p - q;
  endfunction

  function automatic inv_t invert(mat_t m);
    mi3_pkg::entry_t a[3][3];
    logic signed [63:0] adj[9];
    logic signed [129:0] det, num, qt;
    logic [129:0] dmag, mag, q;
    logic neg;
    inv_t r;
    for (int i = 0; i < 9; i++) a[i / 3][i % 3] = m.e[i];
    adj[0] = mul2(a[1][1], a[2][2], a[1][2], a[2][1]);
    adj[1] = mul2(a[0][2], a[2][1], a[0][1], a[2][2]);
    adj[2] = mul2(a[0][1], a[1][2], a[0][2], a[1][1]);
    adj[3] = mul2(a[1][2], a[2][0], a[1][0], a[2][2]);
    adj[4] = mul2(a[0][0], a[2][2], a[0][2], a[2][0]);
    adj[5] = mul2(a[0][2], a[1][0], a[0][0], a[1][2]);
    adj[6] = mul2(a[1][0], a[2][1], a[1][1], a[2][0]);
    adj[7] = mul2(a[0][1], a[2][0], a[0][0], a[2][1]);
    adj[8] = mul2(a[0][0], a[1][1], a[0][1], a[1][0]);
    det = 130'(a[0][0]) * 130'(adj[0]) + 130'(a[0][1]) * 130'(adj[3])
        + 130'(a[0][2]) * 130'(adj[6]);
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      num = 130'(adj[i]);
      mag = num < 0 ? -num : num;
      neg = (num < 0) != (det < 0);
      q = (mag << 48) / dmag;
      if (mag == 0) r.e[i] = '0;
      else if (q > (neg ? 130'h8000_0000 : 130'h7FFF_FFFF)) begin
        r.saturated = 1'b1;
        r.e[i] = neg ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
      end else begin
        qt = neg ? -$signed(q) : $signed(q);
        r.e[i] = qt[31:0];
      end
    end
    return r;
  endfunction

  task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s[%0d]: got %h want %h", what, idx, got, want);
    errors++;
  endtask

  function automatic mat_t rand_mat();
    mat_t m;
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (k)
        0, 1:    m.e[i] = mi3_pkg::entry_t'($urandom);
        2:       m.e[i] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        3:       m.e[i] = mi3_pkg::entry_t'($signed(16'($urandom)));
        default: m.e[i] = mi3_pkg::entry_t'($signed(28'($urandom)));
      endcase
    end
    if (k == 4) for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? m.e[i] : '0;
    if (k == 5) for (int j = 0; j < 3; j++) m.e[6 + j] = m.e[j];
    if (k == 6) for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 32'sd16777216 : 32'sd1;
    return m;
  endfunction

  row_t rows[$];

  task automatic add_row(mat_t m, logic known, inv_t res);
    row_t r;
    r.m = m;
    r.known = known;
    r.res = res;
    rows.push_back(r);
  endtask

  task automatic send(mat_t m);
    while ($urandom_range(0, 3) == 0 && !calm) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
     in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sink side with random stall bursts
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        inv_t got, want;
        got = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0, out_ch.out_r1c2,
               out_ch.out_r1c1, out_ch.out_r1c0, out_ch.out_r0c2, out_ch.out_r0c1,
               out_ch.out_r0c0, out_ch.singular, out_ch.saturated};
        if (inv_q.size() == 0) report("unexpected", 0, 32'd0, 32'd0);
        else begin
          want = inv_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.e[i] !== want.e[i]) report("entry", i, got.e[i], want.e[i]);
          if (got.singular !== want.singular)
            report("singular", 0, 32'(got.singular), 32'(want.singular));
          if (got.saturated !== want.saturated)
            report("saturated", 0, 32'(got.saturated), 32'(want.saturated));
        end
      end
      if (hold > 0) hold--;
      else if (!calm && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 5);
      out_ch.ready <= (hold == 0);
    end
  end

  initial begin
    mat_t m;
    inv_t z, w;
    in_ch.valid <= 1'b0;
    {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
     in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} <= '0;
    z = '0;
    m = '0;
    w = z; w.singular = 1'b1;
    add_row(m, 1'b1, w);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 32'sd16777216 : 32'sd0;
    w = z; w.e[0] = 32'sd16777216; w.e[4] = 32'sd16777216; w.e[8] = 32'sd16777216;
    add_row(m, 1'b1, w);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? -32'sd16777216 : 32'sd0;
    w = z; w.e[0] = -32'sd16777216; w.e[4] = -32'sd16777216; w.e[8] = -32'sd16777216;
    add_row(m, 1'b1, w);
    for (int i = 0; i < 9; i++) m.e[i] = 32'sh7FFF_FFFF;
    w = z; w.singular = 1'b1;
    add_row(m, 1'b1, w);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 32'sd1 : 32'sd0;
    w = z; w.saturated = 1'b1;
    w.e[0] = mi3_pkg::SAT_POS; w.e[4] = mi3_pkg::SAT_POS; w.e[8] = mi3_pkg::SAT_POS;
    add_row(m, 1'b1, w);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? -32'sd1 : 32'sd0;
    w.e[0] = mi3_pkg::SAT_NEG; w.e[4] = mi3_pkg::SAT_NEG; w.e[8] = mi3_pkg::SAT_NEG;
    add_row(m, 1'b1, w);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 32'sh8000_0000 : 32'sd0;
    add_row(m, 1'b0, z);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    add_row(m, 1'b0, z);
    for (int i = 0; i < 9; i++) m.e[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    add_row(m, 1'b0, z);
    m = '0; m.e[2] = 32'sd16777216; m.e[4] = 32'sd33554432; m.e[6] = -32'sd8388608;
    add_row(m, 1'b0, z);
    m = '0; m.e[0] = 32'sd3; m.e[4] = 32'sd16777216; m.e[8] = 32'sh7FFF_FFFF;
    add_row(m, 1'b0, z);
    m = '1;
    add_row(m, 1'b0, z);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[k]) begin
      inv_q.push_back(rows[k].known ? rows[k].res : invert(rows[k].m));
      send(rows[k].m);
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - 150) calm = 1'b1;
      m = rand_mat();
      inv_q.push_back(invert(m));
      send(m);
    end
    in_ch.valid <= 1'b0;
    while (inv_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
